// File: hdl/wma_pkg.sv
// Shared constants, payload types and controller/datapath interface structs.
package wma_pkg;

    localparam int MAX_WINDOW   = 32;
    localparam int SAMPLE_BITS  = 16;
    localparam int PTR_W        = $clog2(MAX_WINDOW);
    localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W        = SAMPLE_BITS + CNT_W;
    localparam int FRAC_W       = 8;
    localparam int AVG_W        = 24;
    localparam int DVD_W        = SUM_W + FRAC_W;
    localparam int REM_W        = DVD_W - AVG_W;
    localparam int DCNT_W       = $clog2(AVG_W + 1);
    localparam int CFG_W        = 6;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_req;

    typedef struct packed {
        logic signed [AVG_W-1:0] average;
        logic                    window_full;
        logic                    last_out;
    } t_out_req;

    typedef struct packed {
        logic accept;
        logic start_sum;
        logic sum_step;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic sum_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: hdl/warmup_moving_average_unit.sv
// Top level of the moving average unit with cumulative warm-up.
//
// Input channel: i_in_valid / o_in_stall carry one sample request (signed
// sample plus a last flag). A request is taken at a clock edge where valid is
// high and stall is low. Output channel: o_out_valid / i_out_stall carry one
// result request per input: the average with 8 fraction bits, a flag that
// tells whether a full window was averaged, and the echoed last flag.
// The window length register is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while the unit is idle, which the unit does not enforce. It resets to 3.
// One request is in flight at a time. After acceptance the unit re-reads the
// n most recent samples from the history ring, one memory read per cycle,
// then runs a 24-step radix-2 divider by n (n from 1 to 32). The next sample
// is taken only after the result has been loaded into the output register.
// Since the result sits in that register, a stalled receiver does not block
// the intake of the next sample; but the next finished result waits until
// the register is free, and no sample is taken while it waits.
// Reset clears the fill count, ring pointer and output valid and loads the
// default window; the history ring itself needs no clearing, because only
// entries written in the current series are ever read. A sample marked last
// empties the history once its result has been produced.
module warmup_moving_average_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wma_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  wma_pkg::t_in_req          i_in_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output wma_pkg::t_out_req         o_out_req
);

    // Commands from the sequencer and status back from the datapath.
    wma_pkg::t_cmd    cmd;
    wma_pkg::t_status status;

    wma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    wma_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule

// File: hdl/wma_ctrl.sv
// Sequencer that steps one request through summing, dividing and output.
module wma_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  wma_pkg::t_status i_status,
    output wma_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_SUM   = 6'b000100,
        S_DINIT = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.start_sum = 1'b1;
                n_state         = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_status.sum_done) begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // No request is taken while reset is held.
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

endmodule

// File: hdl/wma_datapath.sv
// History ring, window sum accumulator, radix-2 divider and output register.
module wma_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wma_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wma_pkg::t_in_req               i_in_req,
    input  wma_pkg::t_cmd                  i_cmd,
    output wma_pkg::t_status               o_status,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output wma_pkg::t_out_req              o_out_req
);

    localparam int PTR_W  = wma_pkg::PTR_W;
    localparam int CNT_W  = wma_pkg::CNT_W;
    localparam int SUM_W  = wma_pkg::SUM_W;
    localparam int SB     = wma_pkg::SAMPLE_BITS;
    localparam int AVG_W  = wma_pkg::AVG_W;
    localparam int REM_W  = wma_pkg::REM_W;
    localparam int DVD_W  = wma_pkg::DVD_W;
    localparam int CFG_W  = wma_pkg::CFG_W;
    localparam int MAXW   = wma_pkg::MAX_WINDOW;

    logic [SB-1:0]          r_mem [MAXW];
    logic [SB-1:0]          r_rd_data;
    logic [CFG_W-1:0]       r_window;
    logic [PTR_W-1:0]       r_wp;
    logic [CNT_W-1:0]       r_fill;
    logic                   r_last;
    logic [CNT_W-1:0]       r_n;
    logic                   r_full;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_rd_left;
    logic                   r_rd_vld;
    logic signed [SUM_W-1:0] r_sum;
    logic                   r_neg;
    logic [REM_W-1:0]       r_rem;
    logic [AVG_W-1:0]       r_quo;
    logic [wma_pkg::DCNT_W-1:0] r_div_cnt;
    logic                   r_out_vld;
    wma_pkg::t_out_req      r_out;

    logic [CNT_W-1:0]       eff_window;
    logic [CNT_W-1:0]       used_cnt;
    logic [PTR_W-1:0]       wp_inc;
    logic [PTR_W-1:0]       wp_dec;
    logic [PTR_W-1:0]       rd_dec;
    logic [SUM_W-1:0]       rd_ext;
    logic [SUM_W-1:0]       sum_mag;
    logic [DVD_W-1:0]       dividend;
    logic [REM_W:0]         trial;
    logic [REM_W:0]         n_ext;
    logic [REM_W:0]         diff;
    logic                   q_bit;
    logic [REM_W-1:0]       rem_next;

    // Window zero acts as one; a window beyond the ring depth acts as the depth.
    always_comb begin
        if ({1'b0, r_window} > (CFG_W + 1)'(MAXW)) begin
            eff_window = CNT_W'(MAXW);
        end else if (r_window == '0) begin
            eff_window = CNT_W'(1);
        end else begin
            eff_window = CNT_W'(r_window);
        end
    end

    assign used_cnt = (r_fill < eff_window) ? r_fill : eff_window;
    assign wp_inc   = (r_wp == PTR_W'(MAXW - 1)) ? '0 : r_wp + PTR_W'(1);
    assign wp_dec   = (r_wp == '0) ? PTR_W'(MAXW - 1) : r_wp - PTR_W'(1);
    assign rd_dec   = (r_rd_ptr == '0) ? PTR_W'(MAXW - 1) : r_rd_ptr - PTR_W'(1);
    assign rd_ext   = {{(SUM_W - SB){r_rd_data[SB-1]}}, r_rd_data};
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign dividend = {sum_mag, wma_pkg::FRAC_W'(0)};

    // One restoring division step per cycle; the remainder always stays below n.
    assign trial    = {r_rem, r_quo[AVG_W-1]};
    assign n_ext    = (REM_W + 1)'(r_n);
    assign diff     = trial - n_ext;
    assign q_bit    = (trial >= n_ext);
    assign rem_next = q_bit ? diff[REM_W-1:0] : trial[REM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_wp] <= i_in_req.sample;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= wma_pkg::WINDOW_RESET;
            r_wp      <= '0;
            r_fill    <= '0;
            r_rd_left <= '0;
            r_rd_vld  <= 1'b0;
            r_sum     <= '0;
            r_div_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_wp <= wp_inc;
                if (r_fill < CNT_W'(MAXW)) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (i_cmd.start_sum) begin
                r_rd_left <= used_cnt;
                r_rd_vld  <= 1'b0;
                r_sum     <= '0;
            end
            if (i_cmd.sum_step) begin
                r_rd_vld <= (r_rd_left != '0);
                if (r_rd_left != '0) begin
                    r_rd_left <= r_rd_left - CNT_W'(1);
                end
                if (r_rd_vld) begin
                    r_sum <= r_sum + $signed(rd_ext);
                end
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= wma_pkg::DCNT_W'(AVG_W);
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - wma_pkg::DCNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
                if (r_last) begin
                    r_wp   <= '0;
                    r_fill <= '0;
                    r_sum  <= '0;
                end
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_last <= i_in_req.last;
        end
        if (i_cmd.start_sum) begin
            r_n      <= used_cnt;
            r_full   <= (used_cnt == eff_window);
            r_rd_ptr <= wp_dec;
        end
        if (i_cmd.sum_step && (r_rd_left != '0)) begin
            r_rd_ptr <= rd_dec;
        end
        if (i_cmd.div_start) begin
            r_neg <= r_sum[SUM_W-1];
            r_rem <= dividend[DVD_W-1:AVG_W];
            r_quo <= dividend[AVG_W-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[AVG_W-2:0], q_bit};
        end
        if (i_cmd.load_out) begin
            r_out.average     <= r_neg ? $signed(-r_quo) : $signed(r_quo);
            r_out.window_full <= r_full;
            r_out.last_out    <= r_last;
        end
    end

    assign o_status.sum_done = (r_rd_left == '0) && !r_rd_vld;
    assign o_status.div_done = (r_div_cnt == '0);
    assign o_status.out_free = !r_out_vld || !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

endmodule

// File: hdl/wma_checker.sv
// Port-level assertions for the moving average unit, bound to the top level.
module wma_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input wma_pkg::t_out_req         o_out_req
);

    // A result waiting on a stalled receiver stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_req))
        else $error("result payload changed while stalled");

    // Once a sample is taken the unit is busy with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second sample accepted while one is in flight");

    // A new result is only produced while a sample is being processed.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a sample in flight");

endmodule

bind warmup_moving_average_unit wma_checker u_wma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);

// File: tb/warmup_moving_average_unit_tb.sv
// Self-checking testbench for the moving average unit with cumulative warm-up.
`timescale 1ns / 100ps

module warmup_moving_average_unit_tb;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 900;
    // No request may take longer than a long sender gap, a full 32-sample sum,
    // the divider and a long receiver stall. This is several times that.
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int PRINT_CAP     = 50;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [wma_pkg::CFG_W-1:0]  i_cfg_wdata = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    wma_pkg::t_in_req           i_in_req    = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    wma_pkg::t_out_req          o_out_req;

    warmup_moving_average_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Sample requests waiting to be sent, and the result requests that the
    // accepted samples must produce, oldest first.
    wma_pkg::t_in_req  pending_samples [$];
    wma_pkg::t_out_req expected_averages [$];

    // Shadow of the unit: the history ring of the current series, its fill
    // count and write pointer, and the window length as last written.
    logic signed [wma_pkg::SAMPLE_BITS-1:0] shadow_ring [wma_pkg::MAX_WINDOW];
    logic [wma_pkg::PTR_W-1:0]              shadow_wp      = '0;
    int unsigned                            shadow_fill    = 0;
    logic [wma_pkg::CFG_W-1:0]              window_setting = wma_pkg::WINDOW_RESET;

    // When clear, neither side inserts gaps or stalls, so back-to-back traffic
    // is exercised too.
    bit idling_on = 1'b0;

    int samples_taken       = 0;
    int results_checked     = 0;
    int full_window_results = 0;
    int series_closed       = 0;
    int windows_written     = 0;
    int mismatch_count      = 0;
    int queued_total        = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Works out the result of one accepted sample and moves the shadow state on.
    task automatic predict_average(input wma_pkg::t_in_req req);
        int unsigned       eff_window;
        int unsigned       span;
        longint            total;
        wma_pkg::t_out_req res;
        eff_window = (window_setting == 0) ? 1 :
                     (window_setting > wma_pkg::MAX_WINDOW) ? wma_pkg::MAX_WINDOW :
                     int'(window_setting);
        shadow_ring[shadow_wp] = req.sample;
        shadow_wp = shadow_wp + 1'b1;
        if (shadow_fill < wma_pkg::MAX_WINDOW)
            shadow_fill++;
        span = (shadow_fill < eff_window) ? shadow_fill : eff_window;
        total = 0;
        for (int unsigned i = 0; i < span; i++)
            total += shadow_ring[wma_pkg::PTR_W'(shadow_wp - 1 - i)];
        // Signed division in SystemVerilog truncates toward zero, as required.
        res.average     = wma_pkg::AVG_W'((total * 256) / longint'(span));
        res.window_full = (span == eff_window);
        res.last_out    = req.last;
        expected_averages.push_back(res);
        if (req.last) begin
            shadow_fill = 0;
            shadow_wp   = '0;
            series_closed++;
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap_length();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 60);
    endfunction

    function automatic logic [wma_pkg::SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(wma_pkg::SAMPLE_BITS-1){1'b0}}};
            1:       return {1'b0, {(wma_pkg::SAMPLE_BITS-1){1'b1}}};
            2:       return wma_pkg::SAMPLE_BITS'($urandom_range(0, 16) - 8);
            default: return wma_pkg::SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Series are mostly of moderate length, some very short, and some long
    // enough to saturate the fill count at the largest window.
    function automatic int draw_series_length();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(1, 3);
            1:       return $urandom_range(33, 100);
            default: return $urandom_range(4, 40);
        endcase
    endfunction

    task automatic queue_sample(input logic [wma_pkg::SAMPLE_BITS-1:0] value,
                                input logic last);
        wma_pkg::t_in_req item;
        item.sample = value;
        item.last   = last;
        pending_samples.push_back(item);
        queued_total++;
    endtask

    // Waits until every queued sample has been taken and every result has
    // come back; the unit is then idle and may be reconfigured.
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || expected_averages.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [wma_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we       <= 1'b1;
        i_cfg_wdata    <= value;
        window_setting  = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        windows_written++;
    endtask

    // Driver: offers sample requests from the pending queue. A stalled request
    // is held unchanged; new gaps are only drawn while nothing is offered.
    int send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_average(i_in_req);
                samples_taken++;
            end
            if (i_in_valid && o_in_stall) begin
                // Hold the current request until the unit takes it.
            end else if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                if (idling_on && $urandom_range(0, 4) == 0) begin
                    send_gap = draw_gap_length() - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_req   <= pending_samples.pop_front();
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result request against the oldest
    // expectation and drives random stalls on the result channel.
    int stall_left = 0;

    always @(posedge i_clk) begin
        wma_pkg::t_out_req want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_averages.size() == 0) begin
                    report_mismatch("result with no sample outstanding",
                                    longint'(o_out_req.average), 0);
                end else begin
                    want = expected_averages.pop_front();
                    if (o_out_req.average !== want.average)
                        report_mismatch("average", longint'(o_out_req.average),
                                        longint'(want.average));
                    if (o_out_req.window_full !== want.window_full)
                        report_mismatch("window_full", longint'(o_out_req.window_full),
                                        longint'(want.window_full));
                    if (o_out_req.last_out !== want.last_out)
                        report_mismatch("last_out", longint'(o_out_req.last_out),
                                        longint'(want.last_out));
                    if (want.window_full)
                        full_window_results++;
                end
                results_checked++;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = draw_gap_length() - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timed out with %0d results outstanding.", expected_averages.size());
        $display("warmup_moving_average_unit: mismatch");
        $finish;
    end

    initial begin
        logic [wma_pkg::CFG_W-1:0] window_corners [8];
        int series_left;
        int phase_len;
        window_corners = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd31, 6'd32, 6'd33, 6'd63};
        series_left = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default window of 3: full-scale positive and negative windows, then
        // a mean of minus one third that must be truncated toward zero.
        repeat (4) queue_sample(16'sh7fff, 1'b0);
        repeat (3) queue_sample(16'sh8000, 1'b0);
        queue_sample(16'shffff, 1'b0);
        queue_sample(16'sh0000, 1'b0);
        queue_sample(16'sh0000, 1'b1);
        wait_idle();

        // A window of zero behaves as a window of one.
        write_window(6'd0);
        queue_sample(16'sd5, 1'b0);
        queue_sample(-16'sd7, 1'b0);
        queue_sample(16'sd3, 1'b1);
        wait_idle();

        // A window beyond the ring size is clamped; the series stays open.
        write_window(6'd63);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(-16'sd3, 1'b0);
        queue_sample(16'sd1, 1'b0);

        wait_idle();
        // Shrinking the window mid-series: the next result already uses it.
        write_window(6'd2);
        queue_sample(16'sd9, 1'b0);
        queue_sample(-16'sd1, 1'b1);
        wait_idle();

        write_window(6'd1);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(16'sh8000, 1'b1);
        wait_idle();

        // Random phases: each one picks a window and an idling mode, then
        // streams well-formed series of random samples. A series may run past
        // the end of a phase, so windows also change in the middle of one.
        while (queued_total < RANDOM_ITEMS + 21) begin
            if ($urandom_range(0, 2) == 0)
                write_window(window_corners[$urandom_range(0, 7)]);
            else
                write_window(wma_pkg::CFG_W'($urandom_range(0, 63)));
            idling_on = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(20, 90);
            for (int k = 0; k < phase_len; k++) begin
                if (series_left == 0)
                    series_left = draw_series_length();
                series_left--;
                queue_sample(draw_sample(), series_left == 0);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results from %0d sample requests in %0d closed series.",
                 results_checked, samples_taken, series_closed);
        $display("Window length written %0d times; %0d results averaged a full window.",
                 windows_written, full_window_results);
        if (mismatch_count == 0 && expected_averages.size() == 0) begin
            $display("warmup_moving_average_unit: match");
        end else begin
            $display("%0d mismatches, %0d results never arrived.",
                     mismatch_count, expected_averages.size());
            $display("warmup_moving_average_unit: mismatch");
        end
        $finish;
    end

endmodule
